>>> sv/lpfs_pkg.sv
package lpfs_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 24;
    localparam int unsigned ID_W   = 32;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(1024 * 256);
    localparam logic [ID_W-1:0]  MIN_LEN       = ID_W'(4);
    localparam logic [ID_W-1:0]  CMD_ID        = '1;

    // event kinds on the result channel
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    typedef enum logic [1:0] {
        PH_LEN,
        PH_ID,
        PH_PAY
    } t_phase;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   id;
        logic              cmd;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_result;

endpackage

>>> sv/lpfs_frame_fsm.sv
module lpfs_frame_fsm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [lpfs_pkg::BYTE_W-1:0] i_byte,
    input  logic [lpfs_pkg::LEN_W-1:0]  i_max_len,
    output logic                        o_res_valid,
    output lpfs_pkg::t_result           o_res
);
    import lpfs_pkg::*;

    t_phase             r_phase, n_phase;
    logic [1:0]         r_hcnt, n_hcnt;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [ID_W-1:0]    r_id, n_id;
    logic [LEN_W-1:0]   r_rem, n_rem;
    logic               r_err, n_err;

    logic               hdr_done;
    logic [ID_W-1:0]    len_asm;
    logic [ID_W-1:0]    id_asm;
    logic               len_bad;
    logic [LEN_W-1:0]   rem_dec;
    logic               live;

    assign live     = i_step && !r_err;
    assign hdr_done = (r_hcnt == 2'd3);
    assign rem_dec  = r_rem - LEN_W'(1);

    // little-endian header assembly, cleared on the first header byte
    always_comb begin
        len_asm = (r_hcnt == 2'd0) ? '0 : {{(ID_W-LEN_W){1'b0}}, r_len};
        len_asm[{r_hcnt, 3'b000} +: BYTE_W] = i_byte;
        id_asm = (r_hcnt == 2'd0) ? '0 : r_id;
        id_asm[{r_hcnt, 3'b000} +: BYTE_W] = i_byte;
    end

    assign len_bad = (len_asm < MIN_LEN)
                  || (len_asm > {{(ID_W-LEN_W){1'b0}}, i_max_len});

    // next state
    always_comb begin
        n_phase = r_phase;
        n_hcnt  = r_hcnt;
        n_len   = r_len;
        n_id    = r_id;
        n_rem   = r_rem;
        n_err   = r_err;
        if (live) begin
            unique case (r_phase)
                PH_PAY: begin
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = PH_LEN;
                    end
                end
                PH_ID: begin
                    n_id   = id_asm;
                    n_hcnt = r_hcnt + 2'd1;
                    if (hdr_done) begin
                        n_phase = (r_rem == '0) ? PH_LEN : PH_PAY;
                    end
                end
                default: begin
                    n_phase = PH_LEN;
                    n_len   = len_asm[LEN_W-1:0];
                    n_hcnt  = r_hcnt + 2'd1;
                    if (hdr_done) begin
                        if (len_bad) begin
                            n_err = 1'b1;
                        end else begin
                            n_rem   = len_asm[LEN_W-1:0] - MIN_LEN[LEN_W-1:0];
                            n_phase = PH_ID;
                        end
                    end
                end
            endcase
        end
    end

    // result for this byte
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        if (live) begin
            unique case (r_phase)
                PH_PAY: begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_PAYLOAD;
                    o_res.id    = r_id;
                    o_res.cmd   = (r_id == CMD_ID);
                    o_res.data  = i_byte;
                    o_res.last  = (rem_dec == '0);
                end
                PH_ID: begin
                    if (hdr_done && r_rem == '0) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_END;
                        o_res.id    = id_asm;
                        o_res.cmd   = (id_asm == CMD_ID);
                        o_res.last  = 1'b1;
                    end
                end
                default: begin
                    if (hdr_done && len_bad) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_ERROR;
                        o_res.last  = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN;
            r_hcnt  <= '0;
            r_len   <= '0;
            r_id    <= '0;
            r_rem   <= '0;
            r_err   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_len   <= n_len;
            r_id    <= n_id;
            r_rem   <= n_rem;
            r_err   <= n_err;
        end
    end

endmodule

>>> sv/length_prefixed_frame_splitter.sv
// Splits a received byte stream into frames of a 4-byte little-endian length,
// a 4-byte little-endian channel id and (length - 4) payload bytes. One byte
// is taken per clock cycle while the input is not stalled; each byte is caught
// in an input register at its transfer, passes the frame decoder and lands in
// the result register once that register is free or draining, from where it
// is presented. A stalled result holds the input register, and the input
// stalls only while both registers are full. Header bytes give no result,
// except an end event on the last id byte of a frame without payload and a
// length error on the last length byte when the length is below 4 or above the
// maximum. After a length error every further byte is swallowed until reset.
// The maximum frame length register resets to 262144 and should only be
// written while no bytes are in flight.
module length_prefixed_frame_splitter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [lpfs_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_event_kind,
    output logic [lpfs_pkg::ID_W-1:0]   o_channel_id,
    output logic                        o_is_command,
    output logic [lpfs_pkg::BYTE_W-1:0] o_payload_byte,
    output logic                        o_last_of_frame,
    input  logic                        i_cfg_we,
    input  logic [lpfs_pkg::LEN_W-1:0]  i_cfg_wdata
);
    import lpfs_pkg::*;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_out_valid;
    t_result            r_out;
    logic [LEN_W-1:0]   r_max_len;

    logic               step;
    logic               in_xfer;
    logic               res_valid;
    t_result            res;

    // the decoder advances whenever a byte is held and the result register is free or draining
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    lpfs_frame_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_max_len   (r_max_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_len   <= MAX_LEN_RESET;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_rx_byte;
        end
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_kind    = r_out.kind;
    assign o_channel_id    = r_out.id;
    assign o_is_command    = r_out.cmd;
    assign o_payload_byte  = r_out.data;
    assign o_last_of_frame = r_out.last;

endmodule

>>> sv/lpfs_checker.sv
module lpfs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic [lpfs_pkg::BYTE_W-1:0] i_rx_byte,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [1:0]                  o_event_kind,
    input logic [lpfs_pkg::ID_W-1:0]   o_channel_id,
    input logic                        o_is_command,
    input logic [lpfs_pkg::BYTE_W-1:0] o_payload_byte,
    input logic                        o_last_of_frame,
    input logic                        i_cfg_we,
    input logic [lpfs_pkg::LEN_W-1:0]  i_cfg_wdata
);
    import lpfs_pkg::*;

    // once an error is transferred the block stays silent
    a_silent_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_event_kind == KIND_ERROR |=> !o_out_valid)
        else $error("result after length error");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind == KIND_ERROR |->
            o_channel_id == '0 && !o_is_command && o_payload_byte == '0 && o_last_of_frame)
        else $error("malformed error event");

    a_command_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_is_command == (o_channel_id == CMD_ID))
        else $error("command flag does not match channel id");

    a_end_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind == KIND_END |-> o_last_of_frame && o_payload_byte == '0)
        else $error("malformed frame end event");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_event_kind)
            && $stable(o_channel_id) && $stable(o_payload_byte) && $stable(o_last_of_frame))
        else $error("stalled result changed");

endmodule

bind length_prefixed_frame_splitter lpfs_checker u_lpfs_checker (.*);

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import lpfs_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_rx_byte = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_event_kind;
    logic [ID_W-1:0]      o_channel_id;
    logic                 o_is_command;
    logic [BYTE_W-1:0]    o_payload_byte;
    logic                 o_last_of_frame;
    logic                 i_cfg_we = 1'b0;
    logic [LEN_W-1:0]     i_cfg_wdata = '0;

    // decoder state as the block should hold it
    t_phase               dec_phase;
    logic [1:0]           dec_hdr_cnt;
    logic [ID_W-1:0]      dec_len;
    logic [ID_W-1:0]      dec_id;
    logic [LEN_W-1:0]     dec_pay_left;
    logic                 dec_locked;
    logic [LEN_W-1:0]     dec_max;

    t_result              pending_events[$];
    int                   err_count = 0;
    int                   events_checked = 0;
    int                   bytes_sent = 0;
    int                   cycle_count = 0;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    logic                 hold_active = 1'b0;
    string                err_case = "none";

    length_prefixed_frame_splitter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_kind    (o_event_kind),
        .o_channel_id    (o_channel_id),
        .o_is_command    (o_is_command),
        .o_payload_byte  (o_payload_byte),
        .o_last_of_frame (o_last_of_frame),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic void frame_decoder_reset();
        dec_phase    = PH_LEN;
        dec_hdr_cnt  = '0;
        dec_len      = '0;
        dec_id       = '0;
        dec_pay_left = '0;
        dec_locked   = 1'b0;
        dec_max      = MAX_LEN_RESET;
    endfunction

    // works out the event, if any, that one transferred byte causes
    function automatic void frame_decode_predict(input logic [BYTE_W-1:0] rx);
        t_result ev;
        ev = '0;
        if (dec_locked)
            return;
        case (dec_phase)
            PH_PAY: begin
                dec_pay_left = dec_pay_left - 1'b1;
                ev.kind = KIND_PAYLOAD;
                ev.id   = dec_id;
                ev.cmd  = (dec_id == CMD_ID);
                ev.data = rx;
                ev.last = (dec_pay_left == '0);
                pending_events.push_back(ev);
                if (ev.last)
                    dec_phase = PH_LEN;
            end
            PH_ID: begin
                if (dec_hdr_cnt == 2'd0)
                    dec_id = '0;
                dec_id |= ID_W'(rx) << (8 * dec_hdr_cnt);
                dec_hdr_cnt = dec_hdr_cnt + 2'd1;
                if (dec_hdr_cnt == 2'd0) begin
                    if (dec_pay_left == '0) begin
                        ev.kind = KIND_END;
                        ev.id   = dec_id;
                        ev.cmd  = (dec_id == CMD_ID);
                        ev.last = 1'b1;
                        pending_events.push_back(ev);
                        dec_phase = PH_LEN;
                    end else begin
                        dec_phase = PH_PAY;
                    end
                end
            end
            default: begin
                dec_phase = PH_LEN;
                if (dec_hdr_cnt == 2'd0)
                    dec_len = '0;
                dec_len |= ID_W'(rx) << (8 * dec_hdr_cnt);
                dec_hdr_cnt = dec_hdr_cnt + 2'd1;
                if (dec_hdr_cnt == 2'd0) begin
                    if (dec_len < MIN_LEN || dec_len > ID_W'(dec_max)) begin
                        dec_locked = 1'b1;
                        ev.kind = KIND_ERROR;
                        ev.last = 1'b1;
                        pending_events.push_back(ev);
                    end else begin
                        dec_pay_left = LEN_W'(dec_len - MIN_LEN);
                        dec_phase    = PH_ID;
                    end
                end
            end
        endcase
    endfunction

    function automatic void report_mismatch(input string field, input logic [31:0] want,
                                            input logic [31:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        err_count++;
    endfunction

    // result side: compare each transfer, then decide the next stall
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event, expected none, actual kind %0d id %h",
                         $time, o_event_kind, o_channel_id);
                err_count++;
            end else begin
                want = pending_events.pop_front();
                events_checked++;
                if (o_event_kind !== want.kind)
                    report_mismatch("event_kind", 32'(want.kind), 32'(o_event_kind));
                if (o_channel_id !== want.id)
                    report_mismatch("channel_id", want.id, o_channel_id);
                if (o_is_command !== want.cmd)
                    report_mismatch("is_command", 32'(want.cmd), 32'(o_is_command));
                if (o_payload_byte !== want.data)
                    report_mismatch("payload_byte", 32'(want.data), 32'(o_payload_byte));
                if (o_last_of_frame !== want.last)
                    report_mismatch("last_of_frame", 32'(want.last), 32'(o_last_of_frame));
            end
        end
        i_out_stall <= hold_active || ($urandom_range(99) < recv_idle_pct);
    end

    task automatic push_rx_byte(input logic [BYTE_W-1:0] rx);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= rx;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        frame_decode_predict(rx);
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            push_rx_byte(w[8*i +: 8]);
    endtask

    task automatic send_random_payload(input int n);
        repeat (n) push_rx_byte(BYTE_W'($urandom));
    endtask

    // input goes quiet until every event is back, plus the pipeline depth
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_length(input logic [LEN_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        dec_max = v;
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    task automatic send_random_frames(input int n_bytes);
        int start;
        int room;
        int n_pay;
        int sel;
        logic [31:0] fid;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            room = int'(dec_max) - 4;
            sel = $urandom_range(99);
            if (sel < 15)
                n_pay = 0;
            else if (sel < 75)
                n_pay = $urandom_range(1, 8);
            else
                n_pay = $urandom_range(9, 48);
            if (n_pay > room)
                n_pay = $urandom_range(0, room);
            sel = $urandom_range(99);
            if (sel < 15)
                fid = CMD_ID;
            else if (sel < 30)
                fid = $urandom_range(0, 3);
            else if (sel < 35)
                fid = CMD_ID - 1;
            else
                fid = $urandom;
            send_word(32'(n_pay) + MIN_LEN);
            send_word(fid);
            send_random_payload(n_pay);
        end
    endtask

    // an empty frame, command id, single-byte and extreme payload values
    task automatic test_directed_frames();
        set_idle(0, 0);
        send_word(MIN_LEN);
        send_word(CMD_ID);
        send_word(32'd5);
        send_word(32'h8000_0001);
        push_rx_byte(8'hFF);
        send_word(32'd6);
        send_word(CMD_ID);
        push_rx_byte(8'h00);
        push_rx_byte(8'h5A);
        wait_drain();
    endtask

    // a frame accepted at the old maximum still completes after it shrinks
    task automatic test_max_change_mid_frame();
        write_max_length(24'd30);
        send_word(32'd30);
        send_word($urandom);
        send_random_payload(5);
        wait_drain();
        write_max_length(LEN_W'(MIN_LEN));
        send_random_payload(21);
        send_random_frames(40);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [LEN_W-1:0] max_len, input int n_bytes);
        set_idle(send_pct, recv_pct);
        write_max_length(max_len);
        send_random_frames(n_bytes);
        wait_drain();
    endtask

    // result side held off long enough that the input has to stall
    task automatic test_output_backpressure();
        set_idle(0, 0);
        fork
            begin
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active <= 1'b0;
            end
        join_none
        repeat (4) begin
            send_word(32'd44);
            send_word($urandom);
            send_random_payload(40);
        end
        wait_drain();
    endtask

    // payload count that crosses into the second length byte
    task automatic test_long_frame();
        set_idle(0, 0);
        send_word(32'd304);
        send_word($urandom);
        send_random_payload(300);
        wait_drain();
    endtask

    // must run last: the block stays shut until reset
    task automatic test_length_error_latch();
        int pick;
        logic [31:0] bad_len;
        set_idle(7, 7);
        pick = $urandom_range(2);
        if (pick == 0) begin
            err_case = "length below minimum";
            bad_len = $urandom_range(0, 3);
        end else begin
            write_max_length(LEN_W'($urandom_range(4, 1000)));
            if (pick == 1) begin
                err_case = "length one above maximum";
                bad_len = ID_W'(dec_max) + 1;
            end else begin
                err_case = "length far above maximum";
                bad_len = $urandom_range(ID_W'(dec_max) + 1, 32'hFFFF_FFFF);
            end
        end
        send_word(bad_len);
        // a well-formed frame afterwards must be swallowed
        send_word(32'd6);
        send_word($urandom);
        send_random_payload(2);
        send_random_payload(16);
        wait_drain();
    endtask

    initial begin
        frame_decoder_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_max_change_mid_frame();
        test_random_traffic(7, 72, LEN_W'($urandom_range(12, 64)), 400);
        test_random_traffic(72, 7, '1, 400);
        test_random_traffic(0, 0, MAX_LEN_RESET, 300);
        test_output_backpressure();
        test_long_frame();
        test_length_error_latch();

        repeat (10) @(posedge i_clk);
        $display("summary: %0d bytes transferred, %0d events checked, maximum swept 4..16777215",
                 bytes_sent, events_checked);
        $display("summary: closing case was %s", err_case);
        if (err_count == 0 && pending_events.size() == 0) begin
            $display("testbench: clean");
        end else begin
            if (pending_events.size() != 0)
                $display("%0t: %0d expected events never arrived", $time,
                         pending_events.size());
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
